### sv/csm_pkg.sv
// Shared package for the caseless substring match block.
// Holds the capacity constant, item mode codes, the cell control struct and case folding.
// No dependencies.
`timescale 1ns / 1ps

package csm_pkg;

	localparam int NEEDLE_MAX = 32;
	localparam int LEN_W      = $clog2(NEEDLE_MAX + 1);

	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;

	typedef enum logic [1:0] {
		MODE_NEEDLE = 2'd0,
		MODE_HAY    = 2'd1,
		MODE_END    = 2'd2,
		MODE_UNUSED = 2'd3
	} mode_t;

	// Control broadcast to every cell of the chain.
	typedef struct packed {
		logic needle_shift;
		logic hay_shift;
		logic hay_clear;
	} cell_ctrl_t;

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			r = c + (CHAR_LOWER_A - CHAR_UPPER_A);
		end
		return r;
	endfunction

endpackage

### sv/csm_cell.sv
// One cell of the match chain: one needle byte, one window byte and their compare.
// Depends on csm_pkg.
`timescale 1ns / 1ps

module csm_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  csm_pkg::cell_ctrl_t ctrl,
	input  logic [7:0]        nbyte_in,
	input  logic              nact_in,
	input  logic [7:0]        wbyte_in,
	input  logic              wval_in,
	output logic [7:0]        nbyte,
	output logic              nact,
	output logic [7:0]        wbyte,
	output logic              wval,
	output logic              hit
);
	import csm_pkg::*;

	logic [7:0] nbyte_q;
	logic [7:0] wbyte_q;
	logic       nact_q;
	logic       wval_q;
	logic       eq_q;

	// Needle and window bytes are payload and need no reset.
	always_ff @(posedge clk) begin
		if (ctrl.needle_shift) begin
			nbyte_q <= nbyte_in;
		end
		if (ctrl.hay_clear) begin
			wbyte_q <= 8'd0;
		end else if (ctrl.hay_shift) begin
			wbyte_q <= wbyte_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nact_q <= 1'b0;
			wval_q <= 1'b0;
			eq_q   <= 1'b0;
		end else begin
			if (ctrl.needle_shift) begin
				nact_q <= nact_in;
			end
			if (ctrl.hay_clear) begin
				wval_q <= 1'b0;
				eq_q   <= 1'b0;
			end else if (ctrl.hay_shift) begin
				wval_q <= wval_in;
				eq_q   <= wval_in && (wbyte_in == nbyte_q);
			end
		end
	end

	assign nbyte = nbyte_q;
	assign nact  = nact_q;
	assign wbyte = wbyte_q;
	assign wval  = wval_q;
	// A cell beyond the needle end never blocks a match.
	assign hit   = eq_q || !nact_q;

endmodule

### sv/caseless_substring_match.sv
// Top level of the caseless substring match block: stream ports, chain of cells, result register.
// Depends on csm_pkg and csm_cell.
`timescale 1ns / 1ps

// Usage
// The input stream carries one byte per transaction in s_tdata; s_tuser gives the mode
// (needle byte, haystack byte, end of haystack) and the first flag that starts a new needle.
// Needle bytes are pushed into a chain of NEEDLE_MAX cells, newest byte in cell 0, so that
// cell j holds the needle byte that lines up with window byte j. Haystack bytes are case
// folded once and shift through the same chain; every cell compares its window byte with
// its needle byte as the byte enters and registers the outcome. The AND of all cell
// outcomes is folded into a sticky match flag in the following cycle.
// An end transaction produces one result transaction: found in m_tdata bit 0 and the
// needle overflow flag in m_tuser. A needle byte or an end transaction clears the
// haystack state. Mode value 3 is accepted and ignored.
// Throughput is one transaction per cycle unless stalled, set by the chain's single shift step.
// A result appears on the master side in the cycle after its end transaction is accepted.
// The result register frees itself when taken, so s_tready is low only while a result
// is held and m_tready is low. Reset clears the needle, the flags and the result register.
module caseless_substring_match (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] byte_value
	input  logic [2:0] s_tuser,  // [1:0] mode, [2] first
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [0] found, [7:1] zero
	output logic       m_tuser   // [0] needle_too_long
);
	import csm_pkg::*;

	logic       in_fire;
	mode_t      in_mode;
	logic       in_first;
	logic [7:0] in_byte;

	logic [LEN_W-1:0] len_q;
	logic             overflow_q;
	logic             match_q;
	logic             pend_q;
	logic             m_tvalid_q;
	logic             found_q;
	logic             too_long_q;

	cell_ctrl_t ctrl;

	logic [NEEDLE_MAX-1:0][7:0] nbyte_in, nbyte_out, wbyte_in, wbyte_out;
	logic [NEEDLE_MAX-1:0]      nact_in, nact_out, wval_in, wval_out, hit;

	logic is_needle, is_hay, is_end, all_match, match_now, found_d;

	assign in_mode  = mode_t'(s_tuser[1:0]);
	assign in_first = s_tuser[2];
	assign in_byte  = s_tdata;

	// The result register parts both sides: a transaction enters unless a held result is not taken.
	assign s_tready = !m_tvalid_q || m_tready;
	assign in_fire  = s_tvalid && s_tready;

	assign is_needle = in_fire && (in_mode == MODE_NEEDLE);
	assign is_hay    = in_fire && (in_mode == MODE_HAY);
	assign is_end    = in_fire && (in_mode == MODE_END);

	// A needle byte is dropped when the chain is full, unless it starts a new needle.
	assign ctrl.needle_shift = is_needle && (in_first || (len_q != LEN_W'(NEEDLE_MAX)));
	assign ctrl.hay_shift    = is_hay;
	assign ctrl.hay_clear    = is_needle || is_end;

	// Cell 0 takes the new bytes; a first byte retires every older needle byte.
	genvar j;
	generate
		for (j = 0; j < NEEDLE_MAX; j++) begin : g_chain
			if (j == 0) begin : g_head
				assign nbyte_in[j] = fold_case(in_byte);
				assign nact_in[j]  = 1'b1;
				assign wbyte_in[j] = fold_case(in_byte);
				assign wval_in[j]  = 1'b1;
			end else begin : g_body
				assign nbyte_in[j] = nbyte_out[j-1];
				assign nact_in[j]  = nact_out[j-1] && !in_first;
				assign wbyte_in[j] = wbyte_out[j-1];
				assign wval_in[j]  = wval_out[j-1];
			end
			csm_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.nbyte_in (nbyte_in[j]),
				.nact_in  (nact_in[j]),
				.wbyte_in (wbyte_in[j]),
				.wval_in  (wval_in[j]),
				.nbyte    (nbyte_out[j]),
				.nact     (nact_out[j]),
				.wbyte    (wbyte_out[j]),
				.wval     (wval_out[j]),
				.hit      (hit[j])
			);
		end
	endgenerate

	// Cell 0 is active exactly when the needle is not empty.
	assign all_match = (&hit) && nact_out[0];
	// Outcome of the haystack byte taken in the previous cycle.
	assign match_now = pend_q && all_match && !overflow_q;

	always_comb begin
		if (overflow_q) begin
			found_d = 1'b0;
		end else if (len_q == '0) begin
			found_d = 1'b1;
		end else begin
			found_d = match_q || match_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			overflow_q <= 1'b0;
			match_q    <= 1'b0;
			pend_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (is_needle) begin
				if (in_first) begin
					len_q      <= LEN_W'(1);
					overflow_q <= 1'b0;
				end else if (len_q == LEN_W'(NEEDLE_MAX)) begin
					overflow_q <= 1'b1;
				end else begin
					len_q <= len_q + LEN_W'(1);
				end
			end
			if (ctrl.hay_clear) begin
				match_q <= 1'b0;
			end else if (match_now) begin
				match_q <= 1'b1;
			end
			pend_q <= is_hay;
			if (is_end) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_end) begin
			found_q    <= found_d;
			too_long_q <= overflow_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, found_q};
	assign m_tuser  = too_long_q;

`ifndef SYNTHESIS
	a_len_matches_active: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(nact_out) == 32'(len_q))
		else $error("needle length disagrees with active cells");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |-> (len_q == LEN_W'(NEEDLE_MAX)))
		else $error("overflow set with a needle below capacity");

	a_needle_clears_hay: assert property (@(posedge clk) disable iff (!arst_n)
		is_needle |=> (wval_out == '0) && !match_q && !pend_q)
		else $error("haystack state survived a needle byte");

	a_too_long_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> !m_tdata[0])
		else $error("found reported with an overlong needle");
`endif

endmodule

### dv/tb_caseless_substring_match.sv
// Self-checking testbench for caseless_substring_match: directed table, then random searches.
// Each result transaction is checked against a predictor in the testbench or a typed verdict.
// Depends on csm_pkg and caseless_substring_match.
`timescale 1ns / 1ps

module tb_caseless_substring_match;
	import csm_pkg::*;

	localparam int ITEM_TARGET = 1500;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int PAT_MAX = NEEDLE_MAX + 8;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] byte_value;
		logic       first;
	} search_item_t;

	typedef struct packed {
		logic found;
		logic too_long;
	} verdict_t;

	// One row of the directed table. A row may repeat its item; a known verdict is
	// typed in only where it is obvious, otherwise the predictor supplies it.
	typedef struct packed {
		mode_t      mode;
		logic [7:0] byte_value;
		logic       first;
		logic [5:0] count;
		logic       typed;
		logic       t_found;
		logic       t_too_long;
	} directed_row_t;

	localparam int DIRECTED_N = 26;
	localparam directed_row_t DIRECTED_ROWS [DIRECTED_N] = '{
		// Empty needle after reset: found even with an empty haystack.
		'{MODE_END,    8'h00, 1'b0, 6'd1,  1'b1, 1'b1, 1'b0},
		'{MODE_HAY,    8'hFF, 1'b1, 6'd1,  1'b0, 1'b0, 1'b0},
		'{MODE_END,    8'hFF, 1'b1, 6'd1,  1'b1, 1'b1, 1'b0},
		// The unused mode leaves everything alone.
		'{MODE_UNUSED, 8'hA5, 1'b1, 6'd1,  1'b0, 1'b0, 1'b0},
		// Needle "aB" built from a first byte and an appended byte.
		'{MODE_NEEDLE, 8'h61, 1'b1, 6'd1,  1'b0, 1'b0, 1'b0},
		'{MODE_NEEDLE, 8'h42, 1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
		'{MODE_HAY,    8'h78, 1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
		'{MODE_HAY,    8'h41, 1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
		'{MODE_HAY,    8'h62, 1'b1, 6'd1,  1'b0, 1'b0, 1'b0},
		'{MODE_END,    8'h00, 1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
		// Haystack shorter than the needle.
		'{MODE_HAY,    8'h61, 1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
		'{MODE_END,    8'h00, 1'b0, 6'd1,  1'b1, 1'b0, 1'b0},
		// Byte extremes.
		'{MODE_NEEDLE, 8'hFF, 1'b1, 6'd1,  1'b0, 1'b0, 1'b0},
		'{MODE_NEEDLE, 8'h00, 1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
		'{MODE_HAY,    8'hFF, 1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
		'{MODE_HAY,    8'h00, 1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
		'{MODE_END,    8'h00, 1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
		// Only letters fold: '[' must not match '{'.
		'{MODE_NEEDLE, 8'h5B, 1'b1, 6'd1,  1'b0, 1'b0, 1'b0},
		'{MODE_HAY,    8'h7B, 1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
		'{MODE_END,    8'h00, 1'b0, 6'd1,  1'b1, 1'b0, 1'b0},
		// Needle at full capacity, matched by a folded haystack.
		'{MODE_NEEDLE, 8'h5A, 1'b1, 6'd1,  1'b0, 1'b0, 1'b0},
		'{MODE_NEEDLE, 8'h5A, 1'b0, 6'd31, 1'b0, 1'b0, 1'b0},
		'{MODE_HAY,    8'h7A, 1'b0, 6'd32, 1'b0, 1'b0, 1'b0},
		'{MODE_END,    8'h00, 1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
		// One byte past capacity: the needle overflows and is reported too long and not found.
		'{MODE_NEEDLE, 8'h71, 1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
		'{MODE_END,    8'h00, 1'b0, 6'd1,  1'b1, 1'b0, 1'b1}
	};

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic [2:0] s_tuser;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       m_tuser;

	caseless_substring_match uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Predictor state: the needle, its overflow flag and the haystack window.
	logic [7:0] needle_bytes [NEEDLE_MAX];
	int         needle_len = 0;
	bit         needle_ovf = 1'b0;
	logic [7:0] hay_window [NEEDLE_MAX];
	int         hay_seen = 0;
	bit         hay_hit = 1'b0;

	verdict_t pending_verdicts [$];
	int       mismatch_count = 0;
	int       items_sent = 0;
	int       send_idle_pct = 30;
	int       recv_idle_pct = 55;
	bit       hold_request = 1'b0;
	int       cycle_count = 0;

	function automatic logic [7:0] lower_letter(input logic [7:0] c);
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			return c ^ 8'h20;
		end
		return c;
	endfunction

	function automatic void clear_haystack();
		int i;
		for (i = 0; i < NEEDLE_MAX; i++) begin
			hay_window[i] = 8'h00;
		end
		hay_seen = 0;
		hay_hit  = 1'b0;
	endfunction

	// Newest window byte sits at index 0, so the last needle byte lines up with it.
	function automatic bit window_holds_needle();
		int i;
		bit hit;
		hit = (needle_len != 0) && (hay_seen >= needle_len);
		for (i = 0; hit && i < needle_len; i++) begin
			if (hay_window[needle_len - 1 - i] != lower_letter(needle_bytes[i])) begin
				hit = 1'b0;
			end
		end
		return hit;
	endfunction

	// Advances the predictor by one accepted item; returns 1 when a verdict is due.
	function automatic bit predict_verdict(input search_item_t it, output verdict_t v);
		int i;
		v = '0;
		case (it.mode)
			MODE_NEEDLE: begin
				if (it.first) begin
					needle_len = 0;
					needle_ovf = 1'b0;
				end
				clear_haystack();
				if (needle_len < NEEDLE_MAX) begin
					needle_bytes[needle_len] = it.byte_value;
					needle_len++;
				end else begin
					needle_ovf = 1'b1;
				end
			end
			MODE_HAY: begin
				for (i = NEEDLE_MAX - 1; i > 0; i--) begin
					hay_window[i] = hay_window[i - 1];
				end
				hay_window[0] = lower_letter(it.byte_value);
				if (hay_seen < NEEDLE_MAX) begin
					hay_seen++;
				end
				if (!needle_ovf && window_holds_needle()) begin
					hay_hit = 1'b1;
				end
			end
			MODE_END: begin
				if (needle_ovf) begin
					v.found = 1'b0;
				end else if (needle_len == 0) begin
					v.found = 1'b1;
				end else begin
					v.found = hay_hit;
				end
				v.too_long = needle_ovf;
				clear_haystack();
				return 1'b1;
			end
			default: begin
			end
		endcase
		return 1'b0;
	endfunction

	// Mostly letters a..d in either case, so that random haystacks hit short needles.
	function automatic logic [7:0] filler_byte();
		if ($urandom_range(9) < 7) begin
			return 8'h61 + 8'($urandom_range(3)) - ($urandom_range(1) ? 8'h20 : 8'h00);
		end
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] random_case(input logic [7:0] c);
		logic [7:0] low;
		low = c | 8'h20;
		if (low >= CHAR_LOWER_A && low <= (CHAR_UPPER_Z | 8'h20) && $urandom_range(1)) begin
			return c ^ 8'h20;
		end
		return c;
	endfunction

	// Offers one transaction, waits for acceptance, then updates the predictor.
	// Ready is sampled at the falling edge, where it is settled for the coming rising edge.
	task automatic send_item(input search_item_t it, input bit typed, input verdict_t typed_v);
		verdict_t v;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= it.byte_value;
		s_tuser  <= {it.first, it.mode};
		@(negedge clk);
		while (!s_tready) begin
			@(negedge clk);
		end
		@(posedge clk);
		if (predict_verdict(it, v)) begin
			pending_verdicts.push_back(typed ? typed_v : v);
		end
		if (it.mode != MODE_UNUSED) begin
			items_sent++;
		end
	endtask

	// One needle followed by a few haystacks, some with the needle planted in mixed case.
	// A few haystacks end without an end transaction, and some groups close with noise.
	task automatic run_search_group();
		logic [7:0]   pattern [PAT_MAX];
		search_item_t it;
		int           plen;
		int           hay_len;
		int           at;
		int           h;
		int           k;
		int           r;
		r = $urandom_range(99);
		if (r < 65) begin
			plen = $urandom_range(1, 6);
		end else if (r < 90) begin
			plen = $urandom_range(7, NEEDLE_MAX);
		end else begin
			plen = $urandom_range(NEEDLE_MAX + 1, PAT_MAX);
		end
		for (k = 0; k < plen; k++) begin
			pattern[k]    = filler_byte();
			it.mode       = MODE_NEEDLE;
			it.byte_value = pattern[k];
			it.first      = (k == 0) ? ($urandom_range(9) != 0) : 1'b0;
			send_item(it, 1'b0, '0);
		end
		for (h = $urandom_range(1, 3); h > 0; h--) begin
			hay_len = $urandom_range(0, plen + 8);
			at = -1;
			if (hay_len >= plen && $urandom_range(9) < 6) begin
				at = $urandom_range(0, hay_len - plen);
			end
			for (k = 0; k < hay_len; k++) begin
				it.mode  = MODE_HAY;
				it.first = 1'($urandom_range(1));
				if (at >= 0 && k >= at && k < at + plen) begin
					it.byte_value = random_case(pattern[k - at]);
				end else begin
					it.byte_value = filler_byte();
				end
				send_item(it, 1'b0, '0);
			end
			if ($urandom_range(9) != 0) begin
				it.mode       = MODE_END;
				it.byte_value = 8'($urandom_range(255));
				it.first      = 1'($urandom_range(1));
				send_item(it, 1'b0, '0);
			end
		end
		if ($urandom_range(9) == 0) begin
			for (k = $urandom_range(1, 5); k > 0; k--) begin
				it.mode       = mode_t'($urandom_range(3));
				it.byte_value = 8'($urandom_range(255));
				it.first      = 1'($urandom_range(1));
				send_item(it, 1'b0, '0);
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever begin
			#1 clk = ~clk;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Receiver: random stalls, plus one long hold-off counted here when the sender asks.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Result checker: outputs are settled at the falling edge before the accepting edge.
	always @(negedge clk) begin : result_check
		verdict_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual found=%0b too_long=%0b",
					$time, m_tdata[0], m_tuser);
				mismatch_count++;
			end else begin
				want = pending_verdicts.pop_front();
				if (m_tdata !== {7'd0, want.found}) begin
					$display("%0t: found mismatch: expected %02h, actual %02h",
						$time, {7'd0, want.found}, m_tdata);
					mismatch_count++;
				end
				if (m_tuser !== want.too_long) begin
					$display("%0t: needle_too_long mismatch: expected %0b, actual %0b",
						$time, want.too_long, m_tuser);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : stimulus
		search_item_t it;
		verdict_t     typed_v;
		int           r;
		int           k;
		bit           hold_done;
		bit           pause_done;
		hold_done  = 1'b0;
		pause_done = 1'b0;
		clear_haystack();
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= 8'h00;
		s_tuser  <= 3'd0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < DIRECTED_N; r++) begin
			for (k = 0; k < DIRECTED_ROWS[r].count; k++) begin
				it.mode       = DIRECTED_ROWS[r].mode;
				it.byte_value = DIRECTED_ROWS[r].byte_value;
				it.first      = DIRECTED_ROWS[r].first;
				typed_v.found    = DIRECTED_ROWS[r].t_found;
				typed_v.too_long = DIRECTED_ROWS[r].t_too_long;
				send_item(it, DIRECTED_ROWS[r].typed, typed_v);
			end
		end

		while (items_sent < ITEM_TARGET) begin
			if (items_sent < 600) begin
				send_idle_pct = 30;
				recv_idle_pct = 55;
			end else if (items_sent < 1100) begin
				send_idle_pct = 55;
				recv_idle_pct = 30;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// Sender pause: let every outstanding result drain before going on.
			if (!pause_done && items_sent >= 700) begin
				pause_done = 1'b1;
				s_tvalid <= 1'b0;
				do begin
					@(posedge clk);
				end while (pending_verdicts.size() != 0);
			end
			// Long receiver hold-off while the sender keeps offering at full rate.
			if (!hold_done && items_sent >= 1200) begin
				hold_done    = 1'b1;
				hold_request = 1'b1;
			end
			run_search_group();
		end

		s_tvalid <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending_verdicts.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
